// ===== sv/ctse_pkg.sv =====
// Shared types and constants for the categorical trial swap engine.
// Used by the top level; depends on nothing else.
`timescale 1ns / 1ps

package ctse_pkg;

  // Fixed field widths of the item and register formats.
  localparam int IDX_W      = 6;
  localparam int DIM_W      = 7;
  localparam int MODE_W     = 2;
  localparam int ITER_W     = 24;
  localparam int ID_W       = 13;
  localparam int CAT_IN_W   = 8;
  localparam int CAT_OUT_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Operation codes carried in an input item.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TRIAL = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // Swap direction selection.
  typedef enum logic [MODE_W-1:0] {
    MODE_VERTICAL   = 2'd0,
    MODE_HORIZONTAL = 2'd1,
    MODE_ALTERNATE  = 2'd2
  } swap_mode_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT  = 2'd0,
    CFG_COL_COUNT  = 2'd1,
    CFG_SWAP_MODE  = 2'd2,
    CFG_ITER_LIMIT = 2'd3
  } cfg_reg_t;

  // One input item.
  typedef struct packed {
    logic [1:0]          operation;
    logic [IDX_W-1:0]    row_a;
    logic [IDX_W-1:0]    row_b;
    logic [IDX_W-1:0]    col_a;
    logic [IDX_W-1:0]    col_b;
    logic [CAT_IN_W-1:0] category_in;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic                 swapped;
    logic                 iteration_closed;
    logic                 finished;
    logic [CAT_OUT_W-1:0] cell_category;
    logic [ID_W-1:0]      cell_id;
  } out_item_t;

endpackage

// ===== sv/ctse_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stands alone; holds the cell words of the swap engine.
`timescale 1ns / 1ps

module ctse_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 4096,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/categorical_trial_swap_engine_top.sv =====
// Top level of the categorical trial swap engine: controller, counters and registers.
// Depends on ctse_pkg and on ctse_ram, which holds {category, cell id} per cell.
// An accepted item is worked on alone: a write, a read, a rejected trial, a trial with bad
// indices, a failed trial and a swapping trial each end with one result strobe, and a new
// item is taken in the cycle the strobe shows.
// The cell memory has a single read and a single write port: a trial reads its four
// cells one per cycle and, on a swap, writes them back one per cycle.
// Reset clears the counters, registers and control; memory holds no reset value.
`timescale 1ns / 1ps

module categorical_trial_swap_engine_top #(
  parameter int MAX_ROWS      = 64,
  parameter int MAX_COLS      = 64,
  parameter int CATEGORY_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  ctse_pkg::in_item_t                  in_item,
  output logic                                out_strobe,
  output ctse_pkg::out_item_t                 out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ctse_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ctse_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int WORD_W   = CATEGORY_BITS + ctse_pkg::ID_W;
  localparam int DIM_MAX  = (2 ** ctse_pkg::DIM_W) - 1;
  localparam int ROWS_TOP = (MAX_ROWS < DIM_MAX) ? MAX_ROWS : DIM_MAX;
  localparam int COLS_TOP = (MAX_COLS < DIM_MAX) ? MAX_COLS : DIM_MAX;
  localparam int TRIAL_W  = $clog2(ROWS_TOP * COLS_TOP + 1);

  localparam int IDX_W  = ctse_pkg::IDX_W;
  localparam int DIM_W  = ctse_pkg::DIM_W;
  localparam int ITER_W = ctse_pkg::ITER_W;
  localparam int ID_W   = ctse_pkg::ID_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_READ,
    ST_CHECK,
    ST_WRITE,
    ST_RDOUT
  } state_t;

  state_t                  state_r;
  ctse_pkg::in_item_t      item_r;
  logic [1:0]              k_r;
  logic [WORD_W-1:0]       word_r [4];
  logic                    out_strobe_r;
  ctse_pkg::out_item_t     out_item_r;
  logic [ITER_W-1:0]       iter_r;
  logic [TRIAL_W-1:0]      trial_r;
  logic [DIM_W-1:0]        row_count_r;
  logic [DIM_W-1:0]        col_count_r;
  logic [ctse_pkg::MODE_W-1:0] swap_mode_r;
  logic [ITER_W-1:0]       iter_limit_r;

  ctse_pkg::op_t           op;
  logic [DIM_W-1:0]        eff_rows;
  logic [DIM_W-1:0]        eff_cols;
  logic [2*DIM_W-1:0]      area_full;
  logic [TRIAL_W-1:0]      area;
  logic                    is_horiz;
  logic                    limit_ok;
  logic                    dims_ok;
  logic                    idx_ok;
  logic                    cell_ok;
  logic [IDX_W-1:0]        k_row;
  logic [IDX_W-1:0]        k_col;
  logic [1:0]              src_sel;
  logic [ID_W:0]           id_full;
  logic [CATEGORY_BITS-1:0] cat_w;
  logic [TRIAL_W-1:0]      trial_inc;
  logic                    fail_close;
  logic [TRIAL_W-1:0]      fail_trial_nxt;
  logic [ITER_W-1:0]       fail_iter_nxt;
  logic [ITER_W-1:0]       iter_inc;
  logic                    board_hit;
  logic [CATEGORY_BITS-1:0] cat_a;
  logic [CATEGORY_BITS-1:0] cat_b;
  logic [CATEGORY_BITS-1:0] cat_c;
  logic [CATEGORY_BITS-1:0] cat_d;
  ctse_pkg::out_item_t     idle_result;
  ctse_pkg::out_item_t     write_result;
  ctse_pkg::out_item_t     fail_result;
  ctse_pkg::out_item_t     swap_result;
  ctse_pkg::out_item_t     read_result;

  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [WORD_W-1:0]       ram_wdata;
  logic [ADDR_W-1:0]       ram_raddr;
  logic [WORD_W-1:0]       ram_rdata;

  // Linear cell address: row-major with a fixed row pitch.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
    cell_addr = ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
  endfunction

  // Matrix size in use, clamped to the storage size.
  always_comb begin
    eff_rows  = (row_count_r > MAX_ROWS) ? DIM_W'(MAX_ROWS) : row_count_r;
    eff_cols  = (col_count_r > MAX_COLS) ? DIM_W'(MAX_COLS) : col_count_r;
    area_full = {{DIM_W{1'b0}}, eff_rows} * {{DIM_W{1'b0}}, eff_cols};
    area      = TRIAL_W'(area_full);
  end

  // Item decode and index checks.
  always_comb begin
    op       = ctse_pkg::op_t'(item_r.operation);
    limit_ok = iter_r < iter_limit_r;
    dims_ok  = (eff_rows >= DIM_W'(2)) && (eff_cols >= DIM_W'(2));
    idx_ok   = ({1'b0, item_r.row_a} < eff_rows) && ({1'b0, item_r.row_b} < eff_rows) &&
               ({1'b0, item_r.col_a} < eff_cols) && ({1'b0, item_r.col_b} < eff_cols) &&
               (item_r.row_a != item_r.row_b) && (item_r.col_a != item_r.col_b);
    cell_ok  = ({1'b0, item_r.row_a} < eff_rows) && ({1'b0, item_r.col_a} < eff_cols);
    k_row    = k_r[1] ? item_r.row_b : item_r.row_a;
    k_col    = k_r[0] ? item_r.col_b : item_r.col_a;
    id_full  = (ID_W + 1)'(item_r.col_a) * (ID_W + 1)'(row_count_r) +
               (ID_W + 1)'(item_r.row_a) + (ID_W + 1)'(1);
    cat_w    = CATEGORY_BITS'(item_r.category_in);
  end

  // Direction of a swap for the current iteration.
  always_comb begin
    case (ctse_pkg::swap_mode_t'(swap_mode_r))
      ctse_pkg::MODE_HORIZONTAL: is_horiz = 1'b1;
      ctse_pkg::MODE_ALTERNATE:  is_horiz = ~iter_r[0];
      default:                   is_horiz = 1'b0;
    endcase
    // A horizontal swap takes each cell from its column partner, a vertical one
    // from its row partner.
    src_sel = is_horiz ? (k_r ^ 2'b01) : (k_r ^ 2'b10);
  end

  // Checkerboard test; the last cell comes straight from the memory read port.
  always_comb begin
    cat_a     = word_r[1][WORD_W-1:ID_W];
    cat_b     = word_r[2][WORD_W-1:ID_W];
    cat_c     = word_r[3][WORD_W-1:ID_W];
    cat_d     = ram_rdata[WORD_W-1:ID_W];
    board_hit = (cat_a != cat_b) && (cat_a == cat_d) && (cat_b == cat_c);
  end

  // Counter updates for a failed trial and for a closed iteration.
  always_comb begin
    trial_inc      = trial_r + TRIAL_W'(1);
    iter_inc       = iter_r + ITER_W'(1);
    fail_close     = trial_inc >= area;
    fail_trial_nxt = fail_close ? '0 : trial_inc;
    fail_iter_nxt  = fail_close ? iter_inc : iter_r;
  end

  // Result items for each way an item can end.
  always_comb begin
    idle_result                  = '0;
    idle_result.finished         = ~limit_ok;

    // A write restarts the counters, so it is finished only with a zero limit.
    write_result                 = '0;
    write_result.finished        = (iter_limit_r == '0);

    fail_result                  = '0;
    fail_result.iteration_closed = fail_close;
    fail_result.finished         = fail_iter_nxt >= iter_limit_r;

    swap_result                  = '0;
    swap_result.swapped          = 1'b1;
    swap_result.iteration_closed = 1'b1;
    swap_result.finished         = iter_inc >= iter_limit_r;

    read_result                  = '0;
    read_result.finished         = ~limit_ok;
    read_result.cell_category    = ctse_pkg::CAT_OUT_W'(ram_rdata[WORD_W-1:ID_W]);
    read_result.cell_id          = ram_rdata[ID_W-1:0];
  end

  // Memory ports. Only one item is in flight, so every write lands before the
  // next item's reads and no forwarding is needed.
  always_comb begin
    ram_we    = ((state_r == ST_DISPATCH) && (op == ctse_pkg::OP_WRITE) && cell_ok) ||
                (state_r == ST_WRITE);
    ram_waddr = (state_r == ST_WRITE) ? cell_addr(k_row, k_col)
                                      : cell_addr(item_r.row_a, item_r.col_a);
    ram_wdata = (state_r == ST_WRITE) ? word_r[src_sel] : {cat_w, id_full[ID_W-1:0]};
    ram_raddr = (state_r == ST_DISPATCH) ? cell_addr(item_r.row_a, item_r.col_a)
                                         : cell_addr(k_row, k_col);
  end

  ctse_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Controller, counters, configuration registers and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      k_r          <= '0;
      out_strobe_r <= 1'b0;
      iter_r       <= '0;
      trial_r      <= '0;
      row_count_r  <= '0;
      col_count_r  <= '0;
      swap_mode_r  <= '0;
      iter_limit_r <= '0;
    end else begin
      out_strobe_r <= 1'b0;

      if (cfg_valid) begin
        unique case (ctse_pkg::cfg_reg_t'(cfg_index))
          ctse_pkg::CFG_ROW_COUNT:  row_count_r  <= cfg_data[DIM_W-1:0];
          ctse_pkg::CFG_COL_COUNT:  col_count_r  <= cfg_data[DIM_W-1:0];
          ctse_pkg::CFG_SWAP_MODE:  swap_mode_r  <= cfg_data[ctse_pkg::MODE_W-1:0];
          ctse_pkg::CFG_ITER_LIMIT: iter_limit_r <= cfg_data[ITER_W-1:0];
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            item_r  <= in_item;
            state_r <= ST_DISPATCH;
          end
        end

        ST_DISPATCH: begin
          unique case (op)
            ctse_pkg::OP_WRITE: begin
              iter_r       <= '0;
              trial_r      <= '0;
              out_item_r   <= write_result;
              out_strobe_r <= 1'b1;
              state_r      <= ST_IDLE;
            end
            ctse_pkg::OP_TRIAL: begin
              if (!(dims_ok && limit_ok)) begin
                out_item_r   <= idle_result;
                out_strobe_r <= 1'b1;
                state_r      <= ST_IDLE;
              end else if (!idx_ok) begin
                trial_r      <= fail_trial_nxt;
                iter_r       <= fail_iter_nxt;
                out_item_r   <= fail_result;
                out_strobe_r <= 1'b1;
                state_r      <= ST_IDLE;
              end else begin
                k_r     <= '0;
                state_r <= ST_READ;
              end
            end
            ctse_pkg::OP_READ: begin
              if (cell_ok) begin
                state_r <= ST_RDOUT;
              end else begin
                out_item_r   <= idle_result;
                out_strobe_r <= 1'b1;
                state_r      <= ST_IDLE;
              end
            end
            default: begin
              out_item_r   <= idle_result;
              out_strobe_r <= 1'b1;
              state_r      <= ST_IDLE;
            end
          endcase
        end

        // One cell read issued per cycle; returned words shift into word_r.
        ST_READ: begin
          if (k_r != 2'd0) begin
            word_r[0] <= word_r[1];
            word_r[1] <= word_r[2];
            word_r[2] <= word_r[3];
            word_r[3] <= ram_rdata;
          end
          k_r <= k_r + 2'd1;
          if (k_r == 2'd3) begin
            state_r <= ST_CHECK;
          end
        end

        ST_CHECK: begin
          word_r[0] <= word_r[1];
          word_r[1] <= word_r[2];
          word_r[2] <= word_r[3];
          word_r[3] <= ram_rdata;
          if (board_hit) begin
            state_r <= ST_WRITE;
          end else begin
            trial_r      <= fail_trial_nxt;
            iter_r       <= fail_iter_nxt;
            out_item_r   <= fail_result;
            out_strobe_r <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end

        // One flipped cell written back per cycle.
        ST_WRITE: begin
          k_r <= k_r + 2'd1;
          if (k_r == 2'd3) begin
            iter_r       <= iter_inc;
            trial_r      <= '0;
            out_item_r   <= swap_result;
            out_strobe_r <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end

        ST_RDOUT: begin
          out_item_r   <= read_result;
          out_strobe_r <= 1'b1;
          state_r      <= ST_IDLE;
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // A result only ever follows a cycle in which an item was being worked on.
  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without an item in progress");

  // An accepted item makes the block busy, with no result, in the cycle after it is taken.
  a_accept_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_strobe))
    else $error("accepted item did not occupy the block");

  // A successful swap always closes the iteration.
  a_swap_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.swapped) |-> out_item.iteration_closed)
    else $error("swap reported without closing the iteration");

  // Cell data is returned only for read items.
  a_data_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && ((out_item.cell_id != '0) || (out_item.cell_category != '0))) |->
      ($past(item_r.operation) == ctse_pkg::OP_READ))
    else $error("cell data returned for a non-read item");

  // The memory is written only while an item is in progress.
  a_write_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> busy)
    else $error("memory written while idle");

endmodule
